/* rtl/brz_pkg.sv */
// ----------------------------------------------------------------------------
// brz_pkg: shared types and constants of the bilinear resize and normalize block
// Holds the register indexes, the channel constants and the queue entry type
// that the front and back parts use.
// ----------------------------------------------------------------------------
package brz_pkg;

   localparam int unsigned MAX_SRC_SIDE_DEF = 1024;
   localparam int unsigned OUT_SIDE_DEF     = 1024;

   // neighbour index width, wide enough for source sides up to 4096
   localparam int unsigned IDX_W  = 12;
   localparam int unsigned SIDE_W = 11;
   localparam int unsigned STEP_W = 27;

   localparam logic [2:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_X_STEP     = 3'd4;
   localparam logic [2:0] CSR_Y_STEP     = 3'd5;

   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   // channel means in q16 and reciprocal standard deviations in q20 (red, green, blue)
   localparam logic [23:0] MEAN_Q16 [3] = '{24'd8105165, 24'd7620526, 24'd6784942};
   localparam logic [14:0] RSTD_Q20 [3] = '{15'd17957, 15'd18357, 15'd18276};

   typedef struct packed {
      logic             kind;    // CMD_WRITE or CMD_COMPUTE
      logic             in_area; // compute: inside resized area; write: inside store
      logic [IDX_W-1:0] x0;
      logic [IDX_W-1:0] x1;
      logic [IDX_W-1:0] y0;
      logic [IDX_W-1:0] y1;
      logic [7:0]       wx;
      logic [7:0]       wy;
      logic [23:0]      rgb;
   } entry_type;

endpackage

/* rtl/brz_front.sv */
// ----------------------------------------------------------------------------
// brz_front: request intake and coordinate mapping
// Holds the configuration registers, classifies each word, maps output
// coordinates to source neighbours and weights, and pushes work entries.
// ----------------------------------------------------------------------------
module brz_front
   import brz_pkg::*;
#(
   parameter int unsigned MAX_SRC_SIDE = MAX_SRC_SIDE_DEF,
   parameter int unsigned OUT_SIDE     = OUT_SIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [26:0] csr_data,
   output logic        push,
   output entry_type   push_entry,
   input  logic        q_full
);

   localparam int unsigned EW = $clog2(MAX_SRC_SIDE + 1);
   localparam int unsigned TW = 38;

   logic [SIDE_W-1:0] src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [STEP_W-1:0] x_step_ff, y_step_ff;

   logic              en;
   logic              f0_valid_ff, f1_valid_ff;
   logic              f0_kind_ff, f0_inside_ff;
   logic [9:0]        f0_x_ff, f0_y_ff;
   logic [23:0]       f0_rgb_ff;
   logic [TW-1:0]     f0_tx_ff, f0_ty_ff;
   entry_type         f1_entry_ff, f1_entry_in;

   logic [9:0]        px, py;
   logic              kind_in, inside_in;
   logic [EW-1:0]     side_x, side_y;
   logic [IDX_W-1:0]  x0, x1, y0, y1;
   logic [7:0]        wx, wy;

   assign en         = !q_full;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign px         = req_tdata[9:0];
   assign py         = req_tdata[19:10];
   assign kind_in    = req_tuser;

   always_comb begin
      if (kind_in == CMD_COMPUTE) begin
         inside_in = ({1'b0, px} < dst_w_ff) && ({1'b0, py} < dst_h_ff)
                     && (32'(px) < OUT_SIDE) && (32'(py) < OUT_SIDE);
      end else begin
         inside_in = (32'(px) < MAX_SRC_SIDE) && (32'(py) < MAX_SRC_SIDE);
      end
   end

   function automatic logic [EW-1:0] eff_side(input logic [SIDE_W-1:0] v);
      logic [EW-1:0] r;
      if (v == '0) begin
         r = EW'(1);
      end else if (32'(v) > MAX_SRC_SIDE) begin
         r = EW'(MAX_SRC_SIDE);
      end else begin
         r = EW'(v);
      end
      return r;
   endfunction

   // t = (2c+1)*step, p = (t - 1.0)/2 floored, clamp to the last column or row
   function automatic logic [IDX_W+IDX_W+8-1:0] map_axis(input logic [TW-1:0] t,
                                                          input logic [EW-1:0] side);
      logic [TW-2:0]    p;
      logic [TW-18:0]   ip;
      logic [IDX_W-1:0] i0, i1, last;
      if (t < TW'(65536)) begin
         p = '0;
      end else begin
         p = (TW-1)'((t - TW'(65536)) >> 1);
      end
      ip   = p[TW-2:16];
      last = IDX_W'(side - EW'(1));
      if (ip > (TW-17)'(last)) begin
         i0 = last;
      end else begin
         i0 = IDX_W'(ip);
      end
      if (32'(i0) + 32'd1 < 32'(side)) begin
         i1 = i0 + IDX_W'(1);
      end else begin
         i1 = last;
      end
      return {i0, i1, p[15:8]};
   endfunction

   assign side_x = eff_side(src_w_ff);
   assign side_y = eff_side(src_h_ff);
   assign {x0, x1, wx} = map_axis(f0_tx_ff, side_x);
   assign {y0, y1, wy} = map_axis(f0_ty_ff, side_y);

   always_comb begin
      f1_entry_in.kind    = f0_kind_ff;
      f1_entry_in.in_area = f0_inside_ff;
      f1_entry_in.rgb     = f0_rgb_ff;
      if (f0_kind_ff == CMD_COMPUTE) begin
         f1_entry_in.x0 = x0;
         f1_entry_in.x1 = x1;
         f1_entry_in.y0 = y0;
         f1_entry_in.y1 = y1;
         f1_entry_in.wx = wx;
         f1_entry_in.wy = wy;
      end else begin
         f1_entry_in.x0 = IDX_W'(f0_x_ff);
         f1_entry_in.x1 = IDX_W'(f0_x_ff);
         f1_entry_in.y0 = IDX_W'(f0_y_ff);
         f1_entry_in.y1 = IDX_W'(f0_y_ff);
         f1_entry_in.wx = '0;
         f1_entry_in.wy = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff    <= SIDE_W'(1024);
         src_h_ff    <= SIDE_W'(1024);
         dst_w_ff    <= SIDE_W'(1024);
         dst_h_ff    <= SIDE_W'(1024);
         x_step_ff   <= STEP_W'(65536);
         y_step_ff   <= STEP_W'(65536);
         f0_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_SRC_WIDTH:  src_w_ff  <= csr_data[SIDE_W-1:0];
               CSR_SRC_HEIGHT: src_h_ff  <= csr_data[SIDE_W-1:0];
               CSR_DST_WIDTH:  dst_w_ff  <= csr_data[SIDE_W-1:0];
               CSR_DST_HEIGHT: dst_h_ff  <= csr_data[SIDE_W-1:0];
               CSR_X_STEP:     x_step_ff <= csr_data;
               CSR_Y_STEP:     y_step_ff <= csr_data;
               default: ;
            endcase
         end
         if (en) begin
            f0_valid_ff <= req_tvalid;
            f1_valid_ff <= f0_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f0_kind_ff   <= kind_in;
         f0_inside_ff <= inside_in;
         f0_x_ff      <= px;
         f0_y_ff      <= py;
         f0_rgb_ff    <= {req_tdata[27:20], req_tdata[35:28], req_tdata[43:36]};
         f0_tx_ff     <= TW'({px, 1'b1}) * TW'(x_step_ff);
         f0_ty_ff     <= TW'({py, 1'b1}) * TW'(y_step_ff);
         f1_entry_ff  <= f1_entry_in;
      end
   end

   assign push       = f1_valid_ff && en;
   assign push_entry = f1_entry_ff;

endmodule

/* rtl/brz_fifo.sv */
// ----------------------------------------------------------------------------
// brz_fifo: short work queue
// Show-ahead queue of work entries between the front and back parts.
// ----------------------------------------------------------------------------
module brz_fifo
   import brz_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      avail,
   output entry_type head
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PW    = $clog2(DEPTH);

   entry_type       slot_ff [DEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [PW:0]     count_ff;

   assign full  = (count_ff == (PW+1)'(DEPTH));
   assign avail = (count_ff != '0);
   assign head  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + PW'(1);
         end
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/brz_back.sv */
// ----------------------------------------------------------------------------
// brz_back: frame store, bilinear blend and normalization
// Four banked stores split by column and row parity give all four neighbours
// in one read; the blend, mean subtract and scale run as a stalling pipeline.
// ----------------------------------------------------------------------------
module brz_back
   import brz_pkg::*;
#(
   parameter int unsigned MAX_SRC_SIDE = MAX_SRC_SIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        avail,
   input  entry_type   head,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic        rsp_tuser
);

   localparam int unsigned HALF   = (MAX_SRC_SIDE + 1) / 2;
   localparam int unsigned BANK_D = HALF * HALF;
   localparam int unsigned BA_W   = $clog2(BANK_D);

   logic en;
   assign en  = !rsp_tvalid || rsp_tready;
   assign pop = en && avail;

   // ---- stage 0: bank access
   logic [BA_W-1:0] addr [4];
   logic            wr_en [4];
   logic [23:0]     rd_ff [4];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic XP = 1'(b % 2);
      localparam logic YP = 1'(b / 2);
      logic [23:0]      mem [BANK_D];
      logic [IDX_W-1:0] col, row;
      assign col = (head.x0[0] == XP) ? head.x0 : head.x1;
      assign row = (head.y0[0] == YP) ? head.y0 : head.y1;
      assign addr[b] = BA_W'(32'(row >> 1) * HALF + 32'(col >> 1));
      assign wr_en[b] = pop && (head.kind == CMD_WRITE) && head.in_area
                        && (head.x0[0] == XP) && (head.y0[0] == YP);
      always_ff @(posedge clock) begin
         if (wr_en[b]) begin
            mem[addr[b]] <= head.rgb;
         end
         if (en) begin
            rd_ff[b] <= mem[addr[b]];
         end
      end
   end

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic        s1_inside_ff, s2_inside_ff, s3_inside_ff, s4_inside_ff;
   logic [1:0]  s1_xp_ff, s1_yp_ff;
   logic [7:0]  s1_wx_ff, s1_wy_ff, s2_wy_ff;
   logic [15:0] s2_top_ff [3], s2_bot_ff [3];
   logic [23:0] s3_val_ff [3];
   logic signed [40:0] s4_prod_ff [3];
   logic [15:0] out_ff [3];
   logic        out_inside_ff;

   // ---- stage 1: horizontal blend
   logic [23:0] p00, p01, p10, p11;
   logic [15:0] top_in [3], bot_in [3];
   assign p00 = rd_ff[{s1_yp_ff[0], s1_xp_ff[0]}];
   assign p01 = rd_ff[{s1_yp_ff[0], s1_xp_ff[1]}];
   assign p10 = rd_ff[{s1_yp_ff[1], s1_xp_ff[0]}];
   assign p11 = rd_ff[{s1_yp_ff[1], s1_xp_ff[1]}];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         top_in[c] = 16'(p00[16-8*c +: 8] * (9'd256 - 9'(s1_wx_ff)))
                   + 16'(p01[16-8*c +: 8] * 9'(s1_wx_ff));
         bot_in[c] = 16'(p10[16-8*c +: 8] * (9'd256 - 9'(s1_wx_ff)))
                   + 16'(p11[16-8*c +: 8] * 9'(s1_wx_ff));
      end
   end

   // ---- stage 2: vertical blend, stage 3: scale, stage 4: round and saturate
   logic [23:0]        val_in [3];
   logic signed [40:0] prod_in [3];
   logic signed [40:0] d_ext [3], r_ext [3];
   logic signed [41:0] rnd [3];
   logic signed [17:0] q [3];
   logic [15:0]        sat_in [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         val_in[c]  = 24'(s2_top_ff[c] * (9'd256 - 9'(s2_wy_ff)))
                    + 24'(s2_bot_ff[c] * 9'(s2_wy_ff));
         d_ext[c]   = 41'(s3_val_ff[c]) - 41'(MEAN_Q16[c]);
         r_ext[c]   = 41'(RSTD_Q20[c]);
         prod_in[c] = d_ext[c] * r_ext[c];
         rnd[c]     = 42'(s4_prod_ff[c]) + 42'sd8388608;
         q[c]       = rnd[c][41:24];
         if (q[c] > 18'sd32767) begin
            sat_in[c] = 16'h7fff;
         end else if (q[c] < -18'sd32768) begin
            sat_in[c] = 16'h8000;
         end else begin
            sat_in[c] = q[c][15:0];
         end
         if (!s4_inside_ff) begin
            sat_in[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         // writes leave the pipeline after the store access
         s1_valid_ff  <= pop && (head.kind == CMD_COMPUTE);
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_inside_ff  <= head.in_area;
         s1_xp_ff      <= {head.x1[0], head.x0[0]};
         s1_yp_ff      <= {head.y1[0], head.y0[0]};
         s1_wx_ff      <= head.wx;
         s1_wy_ff      <= head.wy;
         s2_inside_ff  <= s1_inside_ff;
         s2_wy_ff      <= s1_wy_ff;
         s3_inside_ff  <= s2_inside_ff;
         s4_inside_ff  <= s3_inside_ff;
         out_inside_ff <= s4_inside_ff;
         for (int c = 0; c < 3; c++) begin
            s2_top_ff[c]  <= top_in[c];
            s2_bot_ff[c]  <= bot_in[c];
            s3_val_ff[c]  <= val_in[c];
            s4_prod_ff[c] <= prod_in[c];
            out_ff[c]     <= sat_in[c];
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff[2], out_ff[1], out_ff[0]};
   assign rsp_tuser  = out_inside_ff;

`ifndef SYNTHESIS
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("outside result not zero");
   a_compute_enters: assert property (@(posedge clock) disable iff (reset)
      pop && head.kind == CMD_COMPUTE |=> s1_valid_ff)
      else $error("compute entry lost");
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      pop && head.kind == CMD_WRITE |=> !s1_valid_ff)
      else $error("write entry produced a result");
`endif

endmodule

/* rtl/bilinear_resize_normalize.sv */
// ----------------------------------------------------------------------------
// bilinear_resize_normalize: bilinear resize with mean and std normalization
// Stores source pixels in a 2x2 banked frame store and returns one
// normalized q3.12 rgb result for each compute word.
// ----------------------------------------------------------------------------
// a compute word passes f0, f1, the queue, bank read, blend, scale and round stages
// one word per cycle when not stalled; banked store reads all four neighbours at once
// writes give no result and take one slot of the same pipeline
// reset: configuration returns to 1024x1024 sides and unit steps, pipeline empties
// frame store is not cleared; the user must write pixels before reads; not enforced
module bilinear_resize_normalize
   import brz_pkg::*;
#(
   parameter int unsigned MAX_SRC_SIDE = MAX_SRC_SIDE_DEF,
   parameter int unsigned OUT_SIDE     = OUT_SIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // pix_x, pix_y, red_in, green_in, blue_in, zero pad
   input  logic        req_tuser,  // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // red_norm, green_norm, blue_norm
   output logic        rsp_tuser,  // inside_res
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [26:0] csr_data
);

   logic      push, q_full, pop, avail;
   entry_type push_entry, head;

   brz_front #(
      .MAX_SRC_SIDE(MAX_SRC_SIDE),
      .OUT_SIDE    (OUT_SIDE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push      (push),
      .push_entry(push_entry),
      .q_full    (q_full)
   );

   brz_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (q_full),
      .pop       (pop),
      .avail     (avail),
      .head      (head)
   );

   brz_back #(
      .MAX_SRC_SIDE(MAX_SRC_SIDE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .avail     (avail),
      .head      (head),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
